// ----- rtl/core/nat_translation_table_assert.svh -----
// Assertion macros for the NAT translation table; clocked on clk_i, disabled in reset.
`ifndef NAT_TRANSLATION_TABLE_ASSERT_SVH
`define NAT_TRANSLATION_TABLE_ASSERT_SVH

// Same-cycle implication.
`define NTT_ASSERT_NOW(lbl_, ante_, cons_, msg_) \
  lbl_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |-> (cons_)) \
    else $error(msg_);

// Next-cycle implication.
`define NTT_ASSERT_NEXT(lbl_, ante_, cons_, msg_) \
  lbl_: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante_) |=> (cons_)) \
    else $error(msg_);

`endif

// ----- rtl/core/ntt_pkg.sv -----
// Shared types and constants of the NAT translation table.
package ntt_pkg;

  localparam int unsigned MAP_ENTRIES  = 64;
  localparam int unsigned CONN_ENTRIES = 256;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [16:0] PORT_FIRST        = 17'd1024;
  localparam logic [15:0] ICMP_ID_RESET     = 16'd1;
  localparam logic [3:0]  STATE_SYN_SENT    = 4'd0;
  localparam logic [3:0]  STATE_ESTABLISHED = 4'd1;

  localparam logic [15:0] ICMP_TO_RESET  = 16'd60;
  localparam logic [15:0] EST_TO_RESET   = 16'd7440;
  localparam logic [15:0] TRANS_TO_RESET = 16'd300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXT_IP   = 2'd0,
    CFG_ICMP_TO  = 2'd1,
    CFG_EST_TO   = 2'd2,
    CFG_TRANS_TO = 2'd3
  } ntt_cfg_e;

  typedef enum logic [2:0] {
    FN_LOOKUP_INT = 3'd0,
    FN_LOOKUP_EXT = 3'd1,
    FN_INSERT     = 3'd2,
    FN_TOUCH      = 3'd3,
    FN_ADD        = 3'd4,
    FN_SET        = 3'd5,
    FN_GET        = 3'd6,
    FN_TICK       = 3'd7
  } ntt_func_e;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOPORT = 2'd3
  } ntt_status_e;

  typedef struct packed {
    ntt_func_e   func;
    logic        proto;
    logic [31:0] int_ip;
    logic [15:0] int_port;
    logic [15:0] ext_port;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [3:0]  expect_state;
    logic [3:0]  next_state;
  } ntt_req_t;

  typedef struct packed {
    ntt_status_e status;
    logic [31:0] map_int_ip;
    logic [15:0] map_int_port;
    logic [31:0] map_ext_ip;
    logic [15:0] map_ext_port;
    logic [3:0]  conn_state;
  } ntt_res_t;

  typedef struct packed {
    logic        proto;
    logic [31:0] int_ip;
    logic [15:0] int_port;
    logic [31:0] ext_ip;
    logic [15:0] ext_port;
    logic [31:0] stamp;
  } map_rec_t;

endpackage

// ----- rtl/core/nat_translation_table.sv -----
// NAT translation table: mapping and TCP connection tables with a scanning sequencer.
//
// channel   direction  handshake                        payload
// command   in         start & !busy                    req_i (ntt_req_t)
// result    out        done_o, one cycle, no stall      res_o (ntt_res_t)
// config    in         cfg_valid_i & cfg_ready_o        cfg_index_i, cfg_data_i
//
// Each transaction scans the map memory one entry per cycle (registered read).
// Lookups and inserts take one pass over the map; a TCP insert adds one port-search
// pass over the map, plus one more pass each time a pass moves the candidate port.
// Connection operations whose mapping is found add a connection memory scan;
// the tick scans the map memory and then the connection memory.
// Valid bits reset at once; no clearing pass. Results cannot be stalled.
`include "nat_translation_table_assert.svh"

module nat_translation_table #(
  parameter int unsigned MapEntries  = ntt_pkg::MAP_ENTRIES,
  parameter int unsigned ConnEntries = ntt_pkg::CONN_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ntt_pkg::ntt_req_t              req_i,
  output logic                           done_o,
  output ntt_pkg::ntt_res_t              res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ntt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  localparam int unsigned MapAw  = $clog2(MapEntries);
  localparam int unsigned ConnAw = $clog2(ConnEntries);
  localparam int unsigned IdxW   = (MapAw > ConnAw) ? MapAw : ConnAw;
  localparam int unsigned CntW   = IdxW + 1;
  localparam logic [CntW-1:0] MapLim   = CntW'(MapEntries);
  localparam logic [CntW-1:0] ConnLim  = CntW'(ConnEntries);
  localparam logic [IdxW-1:0] MapLast  = IdxW'(MapEntries - 1);
  localparam logic [IdxW-1:0] ConnLast = IdxW'(ConnEntries - 1);

  typedef struct packed {
    logic [MapAw-1:0] owner;
    logic [31:0]      dest_ip;
    logic [15:0]      dest_port;
    logic [3:0]       state;
    logic [31:0]      stamp;
    logic [15:0]      order;
  } conn_rec_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MSCAN = 9'b000000010,
    S_DEC   = 9'b000000100,
    S_PORT  = 9'b000001000,
    S_CSCAN = 9'b000010000,
    S_CFIN  = 9'b000100000,
    S_TMAP  = 9'b001000000,
    S_TCONN = 9'b010000000,
    S_TFIN  = 9'b100000000
  } state_e;

  function automatic ntt_pkg::ntt_res_t mk_res(input ntt_pkg::ntt_status_e st,
                                               input ntt_pkg::map_rec_t r,
                                               input logic [3:0] cs);
    ntt_pkg::ntt_res_t o;
    o.status       = st;
    o.map_int_ip   = r.int_ip;
    o.map_int_port = r.int_port;
    o.map_ext_ip   = r.ext_ip;
    o.map_ext_port = r.ext_port;
    o.conn_state   = cs;
    return o;
  endfunction

  // Memories
  ntt_pkg::map_rec_t map_mem [MapEntries];
  conn_rec_t         conn_mem [ConnEntries];
  ntt_pkg::map_rec_t map_rd_q;
  conn_rec_t         conn_rd_q;
  logic              map_we, conn_we;
  logic [MapAw-1:0]  map_waddr, map_raddr;
  logic [ConnAw-1:0] conn_waddr, conn_raddr;
  ntt_pkg::map_rec_t map_wdata;
  conn_rec_t         conn_wdata;

  // Control and working registers
  state_e            state_q, state_d;
  ntt_pkg::ntt_req_t req_q, req_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              rd_v_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              mhit_q, mhit_d, mfree_v_q, mfree_v_d;
  logic [MapAw-1:0]  midx_q, midx_d, mfree_q, mfree_d;
  ntt_pkg::map_rec_t mrec_q, mrec_d;
  logic [16:0]       port_q, port_d;
  logic              bump_q, bump_d;
  logic              chit_q, chit_d, cfree_v_q, cfree_v_d;
  logic [ConnAw-1:0] cidx_q, cidx_d, cfree_q, cfree_d;
  conn_rec_t         crec_q, crec_d;
  logic [15:0]       cage_q, cage_d;
  logic [MapEntries-1:0]  map_valid_q, map_valid_d;
  logic [MapEntries-1:0]  drop_q, drop_d, tcp_q, tcp_d, kept_q, kept_d;
  logic [ConnEntries-1:0] conn_valid_q, conn_valid_d;
  logic [31:0]       secs_q, secs_d;
  logic [15:0]       icmp_id_q, icmp_id_d, order_q, order_d;
  logic [31:0]       ext_ip_q;
  logic [15:0]       icmp_to_q, est_to_q, trans_to_q;
  ntt_pkg::ntt_res_t res_q, res_d;
  logic              done_q, done_d;

  // Datapath helpers
  logic              scan_map, scan_conn, issue, last;
  logic [MapAw-1:0]  map_i;
  logic [ConnAw-1:0] conn_j;
  logic              mv, cv, int_match, ext_match, conn_match, conn_exp, port_hit;
  logic [31:0]       map_age, conn_age;
  logic [15:0]       ord_age, conn_limit, ins_port;
  logic [16:0]       port_nx;
  logic              bump_nx, do_add;
  logic [3:0]        set_state;
  ntt_pkg::map_rec_t ins_rec;
  conn_rec_t         new_conn;

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign res_o       = res_q;
  assign cfg_ready_o = 1'b1;

  // Scan address sequencing
  assign scan_map  = (state_q == S_MSCAN) || (state_q == S_PORT) || (state_q == S_TMAP);
  assign scan_conn = (state_q == S_CSCAN) || (state_q == S_TCONN);
  assign issue     = (scan_map && (cnt_q < MapLim)) || (scan_conn && (cnt_q < ConnLim));
  assign last      = rd_v_q && (scan_map ? (rd_idx_q == MapLast) : (rd_idx_q == ConnLast));
  assign map_raddr  = (scan_map && issue) ? cnt_q[MapAw-1:0] : '0;
  assign conn_raddr = (scan_conn && issue) ? cnt_q[ConnAw-1:0] : '0;

  // Entry compare logic
  assign map_i      = rd_idx_q[MapAw-1:0];
  assign conn_j     = rd_idx_q[ConnAw-1:0];
  assign mv         = map_valid_q[map_i];
  assign cv         = conn_valid_q[conn_j];
  assign int_match  = mv && (map_rd_q.proto == req_q.proto) &&
                      (map_rd_q.int_ip == req_q.int_ip) && (map_rd_q.int_port == req_q.int_port);
  assign ext_match  = mv && (map_rd_q.proto == req_q.proto) &&
                      (map_rd_q.ext_port == req_q.ext_port);
  assign conn_match = cv && (conn_rd_q.owner == midx_q) &&
                      (conn_rd_q.dest_ip == req_q.dest_ip) &&
                      (conn_rd_q.dest_port == req_q.dest_port);
  assign map_age    = secs_q - map_rd_q.stamp;
  assign conn_age   = secs_q - conn_rd_q.stamp;
  assign ord_age    = order_q - conn_rd_q.order;
  assign conn_limit = (conn_rd_q.state == ntt_pkg::STATE_ESTABLISHED) ? est_to_q : trans_to_q;
  assign conn_exp   = (conn_age >= {16'd0, conn_limit});
  assign port_hit   = mv && (map_rd_q.ext_port == port_q[15:0]) && !port_q[16];
  assign port_nx    = port_q + {16'd0, port_hit};
  assign bump_nx    = bump_q | port_hit;
  assign set_state  = (crec_q.state == req_q.expect_state) ? req_q.next_state : crec_q.state;

  // New records
  assign ins_port = (state_q == S_PORT) ? port_nx[15:0] : icmp_id_q;
  assign ins_rec  = '{proto: req_q.proto, int_ip: req_q.int_ip, int_port: req_q.int_port,
                     ext_ip: ext_ip_q, ext_port: ins_port, stamp: secs_q};
  assign new_conn = '{owner: midx_q, dest_ip: req_q.dest_ip, dest_port: req_q.dest_port,
                      state: ntt_pkg::STATE_SYN_SENT, stamp: secs_q, order: order_q};

  // Sequencer
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    cnt_d        = issue ? (cnt_q + CntW'(1)) : cnt_q;
    mhit_d       = mhit_q;
    midx_d       = midx_q;
    mrec_d       = mrec_q;
    mfree_v_d    = mfree_v_q;
    mfree_d      = mfree_q;
    port_d       = port_q;
    bump_d       = bump_q;
    chit_d       = chit_q;
    cidx_d       = cidx_q;
    crec_d       = crec_q;
    cage_d       = cage_q;
    cfree_v_d    = cfree_v_q;
    cfree_d      = cfree_q;
    map_valid_d  = map_valid_q;
    conn_valid_d = conn_valid_q;
    drop_d       = drop_q;
    tcp_d        = tcp_q;
    kept_d       = kept_q;
    secs_d       = secs_q;
    icmp_id_d    = icmp_id_q;
    order_d      = order_q;
    res_d        = res_q;
    done_d       = 1'b0;
    map_we       = 1'b0;
    map_waddr    = mfree_q;
    map_wdata    = ins_rec;
    conn_we      = 1'b0;
    conn_waddr   = cfree_q;
    conn_wdata   = new_conn;
    do_add       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d     = req_i;
          cnt_d     = '0;
          mhit_d    = 1'b0;
          mfree_v_d = 1'b0;
          if (req_i.func == ntt_pkg::FN_TICK) begin
            secs_d  = secs_q + 32'd1;
            drop_d  = '0;
            tcp_d   = '0;
            kept_d  = '0;
            state_d = S_TMAP;
          end else begin
            state_d = S_MSCAN;
          end
        end
      end

      // First matching mapping and first free slot
      S_MSCAN: begin
        if (rd_v_q) begin
          if (((req_q.func == ntt_pkg::FN_LOOKUP_INT) || (req_q.func == ntt_pkg::FN_INSERT))
              ? int_match : ext_match) begin
            if (!mhit_q) begin
              mhit_d = 1'b1;
              midx_d = map_i;
              mrec_d = map_rd_q;
            end
          end
          if (!mv && !mfree_v_q) begin
            mfree_v_d = 1'b1;
            mfree_d   = map_i;
          end
          if (last) state_d = S_DEC;
        end
      end

      S_DEC: begin
        case (req_q.func)
          ntt_pkg::FN_LOOKUP_INT, ntt_pkg::FN_LOOKUP_EXT: begin
            res_d   = mhit_q ? mk_res(ntt_pkg::ST_HIT, mrec_q, 4'd0)
                             : mk_res(ntt_pkg::ST_MISS, '0, 4'd0);
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          ntt_pkg::FN_INSERT: begin
            if (mhit_q) begin
              // refresh the existing mapping
              map_we          = 1'b1;
              map_waddr       = midx_q;
              map_wdata       = mrec_q;
              map_wdata.stamp = secs_q;
              res_d   = mk_res(ntt_pkg::ST_HIT, mrec_q, 4'd0);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (!mfree_v_q) begin
              res_d   = mk_res(ntt_pkg::ST_FULL, '0, 4'd0);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (!req_q.proto) begin
              map_we               = 1'b1;
              map_valid_d[mfree_q] = 1'b1;
              icmp_id_d = icmp_id_q + 16'd1;
              res_d     = mk_res(ntt_pkg::ST_HIT, ins_rec, 4'd0);
              done_d    = 1'b1;
              state_d   = S_IDLE;
            end else begin
              cnt_d   = '0;
              port_d  = ntt_pkg::PORT_FIRST;
              bump_d  = 1'b0;
              state_d = S_PORT;
            end
          end
          default: begin
            if (!mhit_q) begin
              res_d   = mk_res(ntt_pkg::ST_MISS, '0, 4'd0);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              cnt_d     = '0;
              chit_d    = 1'b0;
              cfree_v_d = 1'b0;
              state_d   = S_CSCAN;
            end
          end
        endcase
      end

      // Free port search: the candidate steps past used ports until a clean pass or the port range runs out
      S_PORT: begin
        if (rd_v_q) begin
          port_d = port_nx;
          bump_d = bump_nx;
          if (last) begin
            if (port_nx[16]) begin
              res_d   = mk_res(ntt_pkg::ST_NOPORT, '0, 4'd0);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (bump_nx) begin
              cnt_d  = '0;
              bump_d = 1'b0;
            end else begin
              map_we               = 1'b1;
              map_valid_d[mfree_q] = 1'b1;
              res_d   = mk_res(ntt_pkg::ST_HIT, ins_rec, 4'd0);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
        end
      end

      // Newest matching connection and first free slot
      S_CSCAN: begin
        if (rd_v_q) begin
          if (conn_match && (!chit_q || (ord_age < cage_q))) begin
            chit_d = 1'b1;
            cidx_d = conn_j;
            crec_d = conn_rd_q;
            cage_d = ord_age;
          end
          if (!cv && !cfree_v_q) begin
            cfree_v_d = 1'b1;
            cfree_d   = conn_j;
          end
          if (last) state_d = S_CFIN;
        end
      end

      S_CFIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        res_d   = mk_res(ntt_pkg::ST_MISS, mrec_q, 4'd0);
        case (req_q.func)
          ntt_pkg::FN_TOUCH: begin
            if (chit_q) begin
              if (crec_q.state == ntt_pkg::STATE_SYN_SENT) begin
                conn_we          = 1'b1;
                conn_waddr       = cidx_q;
                conn_wdata       = crec_q;
                conn_wdata.stamp = secs_q;
              end
              res_d = mk_res(ntt_pkg::ST_HIT, mrec_q, crec_q.state);
            end else begin
              do_add = 1'b1;
            end
          end
          ntt_pkg::FN_ADD: do_add = 1'b1;
          ntt_pkg::FN_SET: begin
            if (chit_q) begin
              conn_we          = 1'b1;
              conn_waddr       = cidx_q;
              conn_wdata       = crec_q;
              conn_wdata.state = set_state;
              res_d = mk_res(ntt_pkg::ST_HIT, mrec_q, set_state);
            end
          end
          ntt_pkg::FN_GET: begin
            if (chit_q) res_d = mk_res(ntt_pkg::ST_HIT, mrec_q, crec_q.state);
          end
          default: res_d = mk_res(ntt_pkg::ST_MISS, mrec_q, 4'd0);
        endcase
        if (do_add) begin
          if (cfree_v_q) begin
            conn_we                = 1'b1;
            conn_valid_d[cfree_q]  = 1'b1;
            order_d = order_q + 16'd1;
            res_d   = mk_res(ntt_pkg::ST_HIT, mrec_q, ntt_pkg::STATE_SYN_SENT);
          end else begin
            res_d   = mk_res(ntt_pkg::ST_FULL, mrec_q, 4'd0);
          end
        end
      end

      // Tick: classify mappings
      S_TMAP: begin
        if (rd_v_q) begin
          if (mv) begin
            if (!map_rd_q.proto) drop_d[map_i] = (map_age > {16'd0, icmp_to_q});
            else                 tcp_d[map_i]  = 1'b1;
          end
          if (last) begin
            cnt_d   = '0;
            state_d = S_TCONN;
          end
        end
      end

      // Tick: age connections, note TCP mappings that keep one
      S_TCONN: begin
        if (rd_v_q) begin
          if (cv) begin
            if (tcp_q[conn_rd_q.owner]) begin
              if (conn_exp) conn_valid_d[conn_j] = 1'b0;
              else          kept_d[conn_rd_q.owner] = 1'b1;
            end else if (drop_q[conn_rd_q.owner]) begin
              conn_valid_d[conn_j] = 1'b0;
            end
          end
          if (last) state_d = S_TFIN;
        end
      end

      S_TFIN: begin
        map_valid_d = map_valid_q & ~(drop_q | (tcp_q & ~kept_q));
        res_d   = mk_res(ntt_pkg::ST_HIT, '0, 4'd0);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rd_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (conn_we) conn_mem[conn_waddr] <= conn_wdata;
    conn_rd_q <= conn_mem[conn_raddr];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    rd_idx_q <= cnt_q[IdxW-1:0];
    midx_q   <= midx_d;
    mrec_q   <= mrec_d;
    mfree_q  <= mfree_d;
    port_q   <= port_d;
    cidx_q   <= cidx_d;
    crec_q   <= crec_d;
    cage_q   <= cage_d;
    cfree_q  <= cfree_d;
    res_q    <= res_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      rd_v_q       <= 1'b0;
      mhit_q       <= 1'b0;
      mfree_v_q    <= 1'b0;
      bump_q       <= 1'b0;
      chit_q       <= 1'b0;
      cfree_v_q    <= 1'b0;
      map_valid_q  <= '0;
      conn_valid_q <= '0;
      drop_q       <= '0;
      tcp_q        <= '0;
      kept_q       <= '0;
      secs_q       <= '0;
      icmp_id_q    <= ntt_pkg::ICMP_ID_RESET;
      order_q      <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      rd_v_q       <= issue;
      mhit_q       <= mhit_d;
      mfree_v_q    <= mfree_v_d;
      bump_q       <= bump_d;
      chit_q       <= chit_d;
      cfree_v_q    <= cfree_v_d;
      map_valid_q  <= map_valid_d;
      conn_valid_q <= conn_valid_d;
      drop_q       <= drop_d;
      tcp_q        <= tcp_d;
      kept_q       <= kept_d;
      secs_q       <= secs_d;
      icmp_id_q    <= icmp_id_d;
      order_q      <= order_d;
      done_q       <= done_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_ip_q   <= '0;
      icmp_to_q  <= ntt_pkg::ICMP_TO_RESET;
      est_to_q   <= ntt_pkg::EST_TO_RESET;
      trans_to_q <= ntt_pkg::TRANS_TO_RESET;
    end else if (cfg_valid_i) begin
      case (ntt_pkg::ntt_cfg_e'(cfg_index_i))
        ntt_pkg::CFG_EXT_IP:   ext_ip_q   <= cfg_data_i;
        ntt_pkg::CFG_ICMP_TO:  icmp_to_q  <= cfg_data_i[15:0];
        ntt_pkg::CFG_EST_TO:   est_to_q   <= cfg_data_i[15:0];
        ntt_pkg::CFG_TRANS_TO: trans_to_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Checks
  `NTT_ASSERT_NOW(a_done_at_end, $fell(busy), done_o, "busy dropped without a result")
  `NTT_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")
  `NTT_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o, "accepted command not busy")

endmodule
